// ===== rtl/bgu_pkg.sv =====
// ----------------------------------------------------------------------------
// bgu_pkg
// Shared constants, types and the reciprocal table of the grid upscaler.
// ----------------------------------------------------------------------------
package bgu_pkg;

   localparam int SRC_WIDTH   = 32;
   localparam int SRC_HEIGHT  = 24;
   localparam int SAMPLE_BITS = 16;

   localparam int COL_W     = $clog2(SRC_WIDTH);
   localparam int ROW_W     = $clog2(SRC_HEIGHT);
   localparam int SPACING_W = 3;
   localparam int D_W       = SPACING_W + 1;
   localparam int IDX_W     = 8;
   localparam int NUM_W     = SAMPLE_BITS + 5;
   localparam int RECIP_K   = SAMPLE_BITS + 8;
   localparam int RECIP_W   = RECIP_K + 1;
   localparam int PROD_W    = NUM_W + RECIP_W;

   localparam logic [SPACING_W-1:0] SPACING_RESET = 3'd5;

   localparam longint ONE_K = longint'(1) << RECIP_K;

   typedef enum logic {
      ST_IDLE,
      ST_ISSUE
   } state_type;

   typedef struct packed {
      logic           accept;
      logic           issue;
      logic [D_W-1:0] ky;
      logic [D_W-1:0] kx;
      logic           last;
   } cmd_type;

   typedef struct packed {
      logic           adv;
      logic [D_W-1:0] d_cfg;
      logic           row_zero;
      logic           col_zero;
   } status_type;

   // ceil(2^K / d) for d = 1 .. 8
   function automatic logic [RECIP_W-1:0] recip(input logic [D_W-1:0] d);
      logic [RECIP_W-1:0] r;
      case (d)
         4'd1:    r = RECIP_W'(ONE_K);
         4'd2:    r = RECIP_W'(ONE_K / 2);
         4'd3:    r = RECIP_W'((ONE_K + 2) / 3);
         4'd4:    r = RECIP_W'(ONE_K / 4);
         4'd5:    r = RECIP_W'((ONE_K + 4) / 5);
         4'd6:    r = RECIP_W'((ONE_K + 5) / 6);
         4'd7:    r = RECIP_W'((ONE_K + 6) / 7);
         4'd8:    r = RECIP_W'(ONE_K / 8);
         default: r = RECIP_W'(ONE_K);
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/bgu_ram.sv =====
// ----------------------------------------------------------------------------
// bgu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bgu_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/bgu_div.sv =====
// ----------------------------------------------------------------------------
// bgu_div
// Two-stage signed divide by d (1..8), rounded to nearest, ties away from zero.
// ----------------------------------------------------------------------------
module bgu_div (
   input  logic                                clock,
   input  logic                                enable,
   input  logic signed [bgu_pkg::NUM_W-1:0]    num,
   input  logic [bgu_pkg::D_W-1:0]             d,
   output logic signed [bgu_pkg::SAMPLE_BITS-1:0] quo
);

   logic [bgu_pkg::NUM_W-1:0]          mag;
   logic [bgu_pkg::NUM_W-1:0]          biased;
   logic [bgu_pkg::PROD_W-1:0]         prod_in;
   logic [bgu_pkg::PROD_W-1:0]         prod_ff;
   logic                               neg_in;
   logic                               neg_ff;
   logic [bgu_pkg::SAMPLE_BITS:0]      q;
   logic [bgu_pkg::SAMPLE_BITS:0]      q_signed;
   logic [bgu_pkg::SAMPLE_BITS-1:0]    quo_in;
   logic [bgu_pkg::SAMPLE_BITS-1:0]    quo_ff;

   always_comb begin
      neg_in  = num[bgu_pkg::NUM_W-1];
      mag     = neg_in ? bgu_pkg::NUM_W'(-num) : bgu_pkg::NUM_W'(num);
      biased  = mag + bgu_pkg::NUM_W'(d >> 1);
      prod_in = bgu_pkg::PROD_W'(biased) * bgu_pkg::PROD_W'(bgu_pkg::recip(d));
   end

   always_comb begin
      q        = prod_ff[bgu_pkg::RECIP_K +: (bgu_pkg::SAMPLE_BITS + 1)];
      q_signed = neg_ff ? -q : q;
      quo_in   = q_signed[bgu_pkg::SAMPLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         neg_ff  <= neg_in;
         quo_ff  <= quo_in;
      end
   end

   assign quo = $signed(quo_ff);

endmodule

// ===== rtl/bgu_ctrl.sv =====
// ----------------------------------------------------------------------------
// bgu_ctrl
// Request sequencer: accepts a request and steps through its tile points.
// ----------------------------------------------------------------------------
module bgu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  bgu_pkg::status_type  sts,
   output bgu_pkg::cmd_type     cmd
);

   bgu_pkg::state_type          state_ff, state_in;
   logic [bgu_pkg::D_W-1:0]     ky_ff, ky_in;
   logic [bgu_pkg::D_W-1:0]     kx_ff, kx_in;
   logic [bgu_pkg::D_W-1:0]     kx0_ff, kx0_in;
   logic [bgu_pkg::D_W-1:0]     d_ff, d_in;
   logic                        last;

   assign last = (ky_ff == d_ff) && (kx_ff == d_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bgu_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = bgu_pkg::ST_ISSUE;
            end
         end
         bgu_pkg::ST_ISSUE: begin
            if (sts.adv && last) begin
               state_in = bgu_pkg::ST_IDLE;
            end
         end
         default: state_in = bgu_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.issue  = 1'b0;
      case (state_ff)
         bgu_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         bgu_pkg::ST_ISSUE: begin
            cmd.issue = sts.adv;
         end
         default: ;
      endcase
      cmd.ky   = ky_ff;
      cmd.kx   = kx_ff;
      cmd.last = last;
   end

   always_comb begin
      ky_in  = ky_ff;
      kx_in  = kx_ff;
      kx0_in = kx0_ff;
      d_in   = d_ff;
      if (cmd.accept) begin
         d_in   = sts.d_cfg;
         ky_in  = sts.row_zero ? sts.d_cfg : bgu_pkg::D_W'(1);
         kx0_in = sts.col_zero ? sts.d_cfg : bgu_pkg::D_W'(1);
         kx_in  = kx0_in;
      end else if (cmd.issue) begin
         if (kx_ff == d_ff) begin
            kx_in = kx0_ff;
            ky_in = ky_ff + bgu_pkg::D_W'(1);
         end else begin
            kx_in = kx_ff + bgu_pkg::D_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bgu_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      ky_ff  <= ky_in;
      kx_ff  <= kx_in;
      kx0_ff <= kx0_in;
      d_ff   <= d_in;
   end

endmodule

// ===== rtl/bgu_datapath.sv =====
// ----------------------------------------------------------------------------
// bgu_datapath
// Neighbor storage, position counters and the interpolation pipe, horizontal then vertical.
// ----------------------------------------------------------------------------
module bgu_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [bgu_pkg::SPACING_W-1:0]         csr_wdata,
   input  logic signed [bgu_pkg::SAMPLE_BITS-1:0] req_sample,
   input  bgu_pkg::cmd_type                      cmd,
   output bgu_pkg::status_type                   sts,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [bgu_pkg::IDX_W-1:0]             rsp_out_row,
   output logic [bgu_pkg::IDX_W-1:0]             rsp_out_col,
   output logic signed [bgu_pkg::SAMPLE_BITS-1:0] rsp_value,
   output logic                                  rsp_last_of_tile,
   output logic                                  rsp_last_of_frame
);

   typedef struct packed {
      logic [bgu_pkg::IDX_W-1:0] row;
      logic [bgu_pkg::IDX_W-1:0] col;
      logic                      lt;
      logic                      lf;
   } tag_type;

   logic [bgu_pkg::SPACING_W-1:0]          spacing_ff;
   logic [bgu_pkg::ROW_W-1:0]              src_row_ff, src_row_in;
   logic [bgu_pkg::COL_W-1:0]              src_col_ff, src_col_in;
   logic [bgu_pkg::D_W-1:0]                d_cfg;
   logic                                   row_last, col_last;

   logic signed [bgu_pkg::SAMPLE_BITS-1:0] ram_rdata;
   logic signed [bgu_pkg::SAMPLE_BITS-1:0] left_ff, above_left_ff;
   logic signed [bgu_pkg::SAMPLE_BITS-1:0] cur_ff, tl_ff, tr_ff, bl_ff;
   logic [bgu_pkg::IDX_W-1:0]              row_base_ff, row_base_in;
   logic [bgu_pkg::IDX_W-1:0]              col_base_ff, col_base_in;
   logic                                   frame_end_ff;
   logic [bgu_pkg::D_W-1:0]                d_item_ff;
   logic [15:0]                            row_prod, col_prod;

   logic                                   adv;
   logic [bgu_pkg::D_W-1:0]                wx, wy;
   logic signed [bgu_pkg::NUM_W-1:0]       nt_in, nb_in, nv_in;
   logic signed [bgu_pkg::NUM_W-1:0]       nt_a_ff, nb_a_ff, nv_d_ff;
   logic signed [bgu_pkg::SAMPLE_BITS-1:0] ht, hb, vq;
   tag_type                                tag_in;
   tag_type                                tag_a_ff, tag_b_ff, tag_c_ff;
   tag_type                                tag_d_ff, tag_e_ff, tag_f_ff;
   logic [bgu_pkg::D_W-1:0]                ky_a_ff, ky_b_ff, ky_c_ff;
   logic [bgu_pkg::D_W-1:0]                d_a_ff, d_b_ff, d_c_ff, d_d_ff;
   logic                                   va_ff, vb_ff, vc_ff, vd_ff, ve_ff, vf_ff;

   assign d_cfg    = bgu_pkg::D_W'(spacing_ff) + bgu_pkg::D_W'(1);
   assign row_last = (src_row_ff == bgu_pkg::ROW_W'(bgu_pkg::SRC_HEIGHT - 1));
   assign col_last = (src_col_ff == bgu_pkg::COL_W'(bgu_pkg::SRC_WIDTH - 1));
   assign adv      = !vf_ff || rsp_ready;

   assign sts.adv      = adv;
   assign sts.d_cfg    = d_cfg;
   assign sts.row_zero = (src_row_ff == '0);
   assign sts.col_zero = (src_col_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= bgu_pkg::SPACING_RESET;
      end else if (csr_we) begin
         spacing_ff <= csr_wdata;
      end
   end

   bgu_ram #(
      .WIDTH (bgu_pkg::SAMPLE_BITS),
      .DEPTH (bgu_pkg::SRC_WIDTH)
   ) u_row_above (
      .clock (clock),
      .we    (cmd.accept),
      .waddr (src_col_ff),
      .wdata (req_sample),
      .raddr (src_col_ff),
      .rdata (ram_rdata)
   );

   always_comb begin
      src_row_in = src_row_ff;
      src_col_in = src_col_ff;
      if (cmd.accept) begin
         if (col_last) begin
            src_col_in = '0;
            src_row_in = row_last ? '0 : src_row_ff + bgu_pkg::ROW_W'(1);
         end else begin
            src_col_in = src_col_ff + bgu_pkg::COL_W'(1);
         end
      end
      row_prod    = 16'(src_row_ff) * 16'(d_cfg);
      col_prod    = 16'(src_col_ff) * 16'(d_cfg);
      row_base_in = bgu_pkg::IDX_W'(row_prod - 16'(d_cfg));
      col_base_in = bgu_pkg::IDX_W'(col_prod - 16'(d_cfg));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_row_ff <= '0;
         src_col_ff <= '0;
      end else begin
         src_row_ff <= src_row_in;
         src_col_ff <= src_col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_ff        <= req_sample;
         tl_ff         <= above_left_ff;
         tr_ff         <= ram_rdata;
         bl_ff         <= left_ff;
         above_left_ff <= ram_rdata;
         left_ff       <= req_sample;
         row_base_ff   <= row_base_in;
         col_base_ff   <= col_base_in;
         frame_end_ff  <= row_last && col_last;
         d_item_ff     <= d_cfg;
      end
   end

   // drop zero-weight terms so unwritten neighbors never reach the sum
   always_comb begin
      wx     = d_item_ff - cmd.kx;
      nt_in  = ((wx == '0) ? '0 : bgu_pkg::NUM_W'(tl_ff * $signed({1'b0, wx})))
             + bgu_pkg::NUM_W'(tr_ff * $signed({1'b0, cmd.kx}));
      nb_in  = ((wx == '0) ? '0 : bgu_pkg::NUM_W'(bl_ff * $signed({1'b0, wx})))
             + bgu_pkg::NUM_W'(cur_ff * $signed({1'b0, cmd.kx}));
      tag_in.row = row_base_ff + bgu_pkg::IDX_W'(cmd.ky);
      tag_in.col = col_base_ff + bgu_pkg::IDX_W'(cmd.kx);
      tag_in.lt  = cmd.last;
      tag_in.lf  = cmd.last && frame_end_ff;
   end

   bgu_div u_div_top (
      .clock  (clock),
      .enable (adv),
      .num    (nt_a_ff),
      .d      (d_a_ff),
      .quo    (ht)
   );

   bgu_div u_div_bot (
      .clock  (clock),
      .enable (adv),
      .num    (nb_a_ff),
      .d      (d_a_ff),
      .quo    (hb)
   );

   always_comb begin
      wy    = d_c_ff - ky_c_ff;
      nv_in = ((wy == '0) ? '0 : bgu_pkg::NUM_W'(ht * $signed({1'b0, wy})))
            + bgu_pkg::NUM_W'(hb * $signed({1'b0, ky_c_ff}));
   end

   bgu_div u_div_vert (
      .clock  (clock),
      .enable (adv),
      .num    (nv_d_ff),
      .d      (d_d_ff),
      .quo    (vq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
         ve_ff <= 1'b0;
         vf_ff <= 1'b0;
      end else if (adv) begin
         va_ff <= cmd.issue;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
         ve_ff <= vd_ff;
         vf_ff <= ve_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nt_a_ff  <= nt_in;
         nb_a_ff  <= nb_in;
         ky_a_ff  <= cmd.ky;
         d_a_ff   <= d_item_ff;
         tag_a_ff <= tag_in;
         ky_b_ff  <= ky_a_ff;
         d_b_ff   <= d_a_ff;
         tag_b_ff <= tag_a_ff;
         ky_c_ff  <= ky_b_ff;
         d_c_ff   <= d_b_ff;
         tag_c_ff <= tag_b_ff;
         nv_d_ff  <= nv_in;
         d_d_ff   <= d_c_ff;
         tag_d_ff <= tag_c_ff;
         tag_e_ff <= tag_d_ff;
         tag_f_ff <= tag_e_ff;
      end
   end

   assign rsp_valid         = vf_ff;
   assign rsp_out_row       = tag_f_ff.row;
   assign rsp_out_col       = tag_f_ff.col;
   assign rsp_value         = vq;
   assign rsp_last_of_tile  = tag_f_ff.lt;
   assign rsp_last_of_frame = tag_f_ff.lf;

endmodule

// ===== rtl/bilinear_grid_upscaler_top.sv =====
// Pipeline: six pipeline stages lie between the issue of a tile point and its response.
// Throughput: one response per cycle while rsp_ready does not stall the output; a request
// is accepted, then the tile point sequencer issues its points, up to (spacing+1)^2 of them
// (36 at reset spacing, 64 at most). The next request is taken in the cycle after its last point issues.
// Reset: synchronous, clears position counters, sequencer and pipeline valids,
// and loads spacing with 5. Row and neighbor storage is not cleared.
// ----------------------------------------------------------------------------
// bilinear_grid_upscaler_top
// Streaming integer-factor bilinear upscaler for a 32 by 24 frame.
// ----------------------------------------------------------------------------
module bilinear_grid_upscaler_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [bgu_pkg::SPACING_W-1:0]         csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [bgu_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [bgu_pkg::IDX_W-1:0]             rsp_out_row,
   output logic [bgu_pkg::IDX_W-1:0]             rsp_out_col,
   output logic signed [bgu_pkg::SAMPLE_BITS-1:0] rsp_value,
   output logic                                  rsp_last_of_tile,
   output logic                                  rsp_last_of_frame
);

   bgu_pkg::cmd_type    cmd;
   bgu_pkg::status_type sts;

   bgu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bgu_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_sample        (req_sample),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_value         (rsp_value),
      .rsp_last_of_tile  (rsp_last_of_tile),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

// ===== tb/bilinear_grid_upscaler_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_grid_upscaler_top_tb
// Streams source pixels into the grid upscaler and checks every tile point.
// A shadow model of the row store, the neighbors and the position counters
// predicts each tile when a request is taken. Every response is compared with
// the oldest predicted point. Directed extremes come first, then random phases
// at random spacings. The sender works in bursts
// and the receiver stalls on a mode pattern of its own.
// ----------------------------------------------------------------------------
module bilinear_grid_upscaler_top_tb;

   typedef struct {
      logic [bgu_pkg::IDX_W-1:0]              out_row;
      logic [bgu_pkg::IDX_W-1:0]              out_col;
      logic signed [bgu_pkg::SAMPLE_BITS-1:0] value;
      logic                                   last_of_tile;
      logic                                   last_of_frame;
   } tile_point_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   csr_we = 1'b0;
   logic [bgu_pkg::SPACING_W-1:0]          csr_wdata = '0;
   logic                                   req_valid = 1'b0;
   logic                                   req_ready;
   logic signed [bgu_pkg::SAMPLE_BITS-1:0] req_sample = '0;
   logic                                   rsp_valid;
   logic                                   rsp_ready = 1'b0;
   logic [bgu_pkg::IDX_W-1:0]              rsp_out_row;
   logic [bgu_pkg::IDX_W-1:0]              rsp_out_col;
   logic signed [bgu_pkg::SAMPLE_BITS-1:0] rsp_value;
   logic                                   rsp_last_of_tile;
   logic                                   rsp_last_of_frame;

   // shadow state of the upscaler
   logic signed [bgu_pkg::SAMPLE_BITS-1:0] above_row [bgu_pkg::SRC_WIDTH];
   logic signed [bgu_pkg::SAMPLE_BITS-1:0] left_val;
   logic signed [bgu_pkg::SAMPLE_BITS-1:0] above_left_val;
   int                                     pos_row;
   int                                     pos_col;
   logic [bgu_pkg::SPACING_W-1:0]          spacing_shadow;

   tile_point_type pending_points[$];

   int          mismatch_count = 0;
   int          requests_taken = 0;
   int          points_checked = 0;
   int          frame_ends = 0;
   logic [7:0]  spacing_seen = '0;
   int          burst_left = 0;
   int          random_sent = 0;
   logic signed [bgu_pkg::SAMPLE_BITS-1:0] last_drawn = '0;

   int          stall_mode = 0;
   int          stall_mode_left = 0;
   logic [7:0]  stall_tick = '0;

   bilinear_grid_upscaler_top dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_value         (rsp_value),
      .rsp_last_of_tile  (rsp_last_of_tile),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #50_000_000;
      $display("timeout: %0d tile points still pending", pending_points.size());
      $display("end of test: mismatches");
      $finish;
   end

   // distance-weighted average, rounded to nearest with ties away from zero
   function automatic longint weigh(input longint a, input longint b, input int k, input int d);
      longint n;
      n = a * (d - k) + b * k;
      if (n >= 0) begin
         return (n + d / 2) / d;
      end
      return -((-n + d / 2) / d);
   endfunction

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0t] %s", $realtime, msg);
      end
   endtask

   task automatic predict_tile(input logic signed [bgu_pkg::SAMPLE_BITS-1:0] cur);
      int             d;
      int             ky0;
      int             kx0;
      longint         top_l;
      longint         top_r;
      longint         bot_l;
      longint         ht;
      longint         hb;
      longint         v;
      bit             frame_end;
      tile_point_type pt;
      d = int'(spacing_shadow) + 1;
      top_l = above_left_val;
      top_r = above_row[pos_col];
      bot_l = left_val;
      ky0 = (pos_row == 0) ? d : 1;
      kx0 = (pos_col == 0) ? d : 1;
      frame_end = (pos_row == bgu_pkg::SRC_HEIGHT - 1) && (pos_col == bgu_pkg::SRC_WIDTH - 1);
      for (int ky = ky0; ky <= d; ky++) begin
         for (int kx = kx0; kx <= d; kx++) begin
            ht = weigh(top_l, top_r, kx, d);
            hb = weigh(bot_l, longint'(cur), kx, d);
            v = weigh(ht, hb, ky, d);
            pt.out_row = bgu_pkg::IDX_W'(pos_row * d + ky - d);
            pt.out_col = bgu_pkg::IDX_W'(pos_col * d + kx - d);
            pt.value = bgu_pkg::SAMPLE_BITS'(v);
            pt.last_of_tile = (ky == d) && (kx == d);
            pt.last_of_frame = pt.last_of_tile && frame_end;
            pending_points.push_back(pt);
         end
      end
      above_left_val = above_row[pos_col];
      above_row[pos_col] = cur;
      left_val = cur;
      if (pos_col == bgu_pkg::SRC_WIDTH - 1) begin
         pos_col = 0;
         pos_row = (pos_row == bgu_pkg::SRC_HEIGHT - 1) ? 0 : pos_row + 1;
      end else begin
         pos_col++;
      end
   endtask

   always @(posedge clock) begin : tile_check
      tile_point_type exp_pt;
      if (reset) begin
         foreach (above_row[i]) above_row[i] = '0;
         left_val = '0;
         above_left_val = '0;
         pos_row = 0;
         pos_col = 0;
         spacing_shadow = bgu_pkg::SPACING_RESET;
      end else begin
         if (req_valid && req_ready) begin
            spacing_seen[spacing_shadow] = 1'b1;
            requests_taken++;
            predict_tile(req_sample);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_points.size() == 0) begin
               note_failure($sformatf("unexpected point row %0d col %0d value %0d",
                                      rsp_out_row, rsp_out_col, rsp_value));
            end else begin
               exp_pt = pending_points.pop_front();
               points_checked++;
               if (rsp_last_of_frame === 1'b1) frame_ends++;
               if (rsp_out_row !== exp_pt.out_row || rsp_out_col !== exp_pt.out_col ||
                   rsp_value !== exp_pt.value || rsp_last_of_tile !== exp_pt.last_of_tile ||
                   rsp_last_of_frame !== exp_pt.last_of_frame) begin
                  note_failure({
                     $sformatf("point mismatch: exp row %0d col %0d val %0d lt %b lf %b,",
                               exp_pt.out_row, exp_pt.out_col, exp_pt.value,
                               exp_pt.last_of_tile, exp_pt.last_of_frame),
                     $sformatf(" got row %0d col %0d val %0d lt %b lf %b",
                               rsp_out_row, rsp_out_col, rsp_value,
                               rsp_last_of_tile, rsp_last_of_frame)});
               end
            end
         end
         if (csr_we) spacing_shadow = csr_wdata;
      end
   end

   // receiver: stall modes of random length
   always @(posedge clock) begin
      stall_tick <= stall_tick + 8'd1;
      if (stall_mode_left == 0) begin
         stall_mode <= $urandom_range(0, 4);
         stall_mode_left <= $urandom_range(20, 200);
      end else begin
         stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= (stall_tick[1:0] == 2'd0);
         3: rsp_ready <= (stall_tick[2:0] == 3'd0);
         default: rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   task automatic send_sample(input logic signed [bgu_pkg::SAMPLE_BITS-1:0] s);
      int gap;
      req_valid <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_tiles();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_points.size() != 0);
   endtask

   task automatic write_spacing(input logic [bgu_pkg::SPACING_W-1:0] v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic signed [bgu_pkg::SAMPLE_BITS-1:0] draw_sample();
      logic signed [bgu_pkg::SAMPLE_BITS-1:0] s;
      case ($urandom_range(0, 7))
         0: s = 16'sh7FFF;
         1: s = -16'sh8000;
         2: s = bgu_pkg::SAMPLE_BITS'($urandom_range(0, 32)) - 16'sd16;
         3: s = ($urandom_range(0, 1) != 0) ? -16'sd1 : 16'sd0;
         4: s = last_drawn + (bgu_pkg::SAMPLE_BITS'($urandom_range(0, 64)) - 16'sd32);
         default: s = bgu_pkg::SAMPLE_BITS'($urandom);
      endcase
      last_drawn = s;
      return s;
   endfunction

   function automatic logic [bgu_pkg::SPACING_W-1:0] draw_spacing();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return bgu_pkg::SPACING_W'($urandom_range(0, 3));
         6, 7:             return bgu_pkg::SPACING_W'($urandom_range(4, 6));
         default:          return bgu_pkg::SPACING_W'(7);
      endcase
   endfunction

   task automatic test_default_spacing_extremes();
      logic signed [bgu_pkg::SAMPLE_BITS-1:0] vals [12];
      vals = '{16'sh7FFF, -16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1,
               -16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sd3, -16'sd3};
      foreach (vals[i]) send_sample(vals[i]);
      drain_tiles();
   endtask

   task automatic test_spacing_extremes();
      logic signed [bgu_pkg::SAMPLE_BITS-1:0] vals [6];
      vals = '{-16'sh8000, 16'sh7FFF, 16'sd0, 16'sh5555, -16'sh5556, 16'sd1};
      write_spacing(bgu_pkg::SPACING_W'(0));
      for (int i = 0; i < 5; i++) send_sample(vals[i]);
      drain_tiles();
      write_spacing(bgu_pkg::SPACING_W'(7));
      foreach (vals[i]) send_sample(vals[i]);
      drain_tiles();
   endtask

   task automatic test_random_frames();
      int phase_len;
      logic [bgu_pkg::SPACING_W-1:0] sp;
      while (random_sent < 480) begin
         sp = draw_spacing();
         write_spacing(sp);
         phase_len = (sp == bgu_pkg::SPACING_W'(7)) ? $urandom_range(10, 40)
                                                    : $urandom_range(20, 120);
         if (phase_len > 480 - random_sent) phase_len = 480 - random_sent;
         for (int i = 0; i < phase_len; i++) begin
            send_sample(draw_sample());
            random_sent++;
         end
         drain_tiles();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_spacing_extremes();
      test_spacing_extremes();
      test_random_frames();
      drain_tiles();
      repeat (20) @(posedge clock);
      if (pending_points.size() != 0) begin
         note_failure($sformatf("%0d tile points never arrived", pending_points.size()));
      end
      $display("covered %0d requests and %0d tile points, %0d frame ends seen",
               requests_taken, points_checked, frame_ends);
      $display("spacing values used (bit per value): %b, failures: %0d",
               spacing_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/bgu_pkg.sv
rtl/bgu_ram.sv
rtl/bgu_div.sv
rtl/bgu_ctrl.sv
rtl/bgu_datapath.sv
rtl/bilinear_grid_upscaler_top.sv
tb/bilinear_grid_upscaler_top_tb.sv
